>>> rtl/kpcq_pkg.sv
// Shared types and constants for the keyed priority command queue.
// Used by every module of the block; depends on nothing else.
package kpcq_pkg;

	// Default number of entries in the sorted store.
	localparam int unsigned CAPACITY_DEFAULT = 16;

	// Key and value widths and the packed entry that holds them.
	localparam int unsigned KEY_W   = 8;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned ENTRY_W = KEY_W + VALUE_W;

	// Value returned whenever no entry is removed.
	localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = 8'sd127;

	// Operation codes on the command port.
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	// Outcome of a command, as reported on add_status.
	typedef enum logic [1:0] {
		STAT_INSERTED = 2'd0,
		STAT_IGNORED  = 2'd1,
		STAT_DROPPED  = 2'd2,
		STAT_NOT_ADD  = 2'd3
	} kpcq_status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CNT_RD,
		S_CNT_CHK,
		S_CMP_RD,
		S_CMP_CHK,
		S_INS_START,
		S_INS_RD,
		S_INS_CHK,
		S_TAKE_HEAD,
		S_TAKE_RD,
		S_TAKE_WR
	} kpcq_state_t;

	// Result of the shared key comparator.
	typedef struct packed {
		logic eq;
		logic gt;
	} kpcq_cmp_t;

endpackage

>>> rtl/keyed_priority_command_queue.sv
// Top level of the keyed priority command queue: sorted (key, value) store,
// shared key comparator and sequencer. Depends on kpcq_pkg and its modules.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------------
//  command   | start, busy (taken: start | operation, key, value, allow_duplicate
//            | high while busy low)      |
//  result    | done (one cycle strobe)   | taken_value, was_empty, add_status
//
// Every command gives exactly one result; busy stays high until it is shown.
// Each entry is visited by a registered memory read, then a compare and write.
// A take walks all stored entries; an add that is not dropped walks down from
// the top of the store to its insertion point. The unique-key rule adds a
// counting pass and, when several entries hold the key, a compaction pass.
// The done strobe comes in the first cycle with busy low.
// A take on an empty store answers on the cycle after it is accepted.
// Reset empties the store at once; entry memory needs no clearing.
// The receiver cannot stall: done is high for one cycle only.
module keyed_priority_command_queue #(
	parameter int unsigned CAPACITY = kpcq_pkg::CAPACITY_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic signed [kpcq_pkg::KEY_W-1:0]   key,
	input  logic signed [kpcq_pkg::VALUE_W-1:0] value,
	input  logic                                allow_duplicate,
	output logic                                done,
	output logic signed [kpcq_pkg::VALUE_W-1:0] taken_value,
	output logic                                was_empty,
	output logic [1:0]                          add_status
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic                                mem_we;
	logic [AW-1:0]                       mem_waddr;
	logic [kpcq_pkg::ENTRY_W-1:0]        mem_wdata;
	logic                                mem_re;
	logic [AW-1:0]                       mem_raddr;
	logic [kpcq_pkg::ENTRY_W-1:0]        mem_rdata;
	logic signed [kpcq_pkg::KEY_W-1:0]   ref_key;
	logic signed [kpcq_pkg::KEY_W-1:0]   stored_key;
	kpcq_pkg::kpcq_cmp_t                 cmp;

	// Key field of the entry just read.
	assign stored_key = mem_rdata[kpcq_pkg::ENTRY_W-1:kpcq_pkg::VALUE_W];

	// Sorted entry store.
	kpcq_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Shared key comparator.
	kpcq_cmp u_cmp (
		.stored_key (stored_key),
		.ref_key    (ref_key),
		.result     (cmp)
	);

	// Command sequencer.
	kpcq_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.operation       (operation),
		.key             (key),
		.value           (value),
		.allow_duplicate (allow_duplicate),
		.busy            (busy),
		.done            (done),
		.taken_value     (taken_value),
		.was_empty       (was_empty),
		.add_status      (add_status),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_re          (mem_re),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata),
		.ref_key         (ref_key),
		.cmp             (cmp)
	);

endmodule

>>> rtl/kpcq_store.sv
// Entry memory of the queue: one write port and one registered read port.
// Depends on kpcq_pkg for the entry width.
module kpcq_store #(
	parameter int unsigned CAPACITY = kpcq_pkg::CAPACITY_DEFAULT,
	parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [AW-1:0]                   waddr,
	input  logic [kpcq_pkg::ENTRY_W-1:0]    wdata,
	input  logic                            re,
	input  logic [AW-1:0]                   raddr,
	output logic [kpcq_pkg::ENTRY_W-1:0]    rdata
);

	logic [kpcq_pkg::ENTRY_W-1:0] mem_q [CAPACITY];
	logic [kpcq_pkg::ENTRY_W-1:0] rdata_q;

	// Write port; entries hold no reset value.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/kpcq_cmp.sv
// Shared key comparator: equality and signed greater-than on one key pair.
// Depends on kpcq_pkg for the key width and the result struct.
module kpcq_cmp (
	input  logic signed [kpcq_pkg::KEY_W-1:0] stored_key,
	input  logic signed [kpcq_pkg::KEY_W-1:0] ref_key,
	output kpcq_pkg::kpcq_cmp_t               result
);

	// One compare serves counting, compaction and the insertion shift.
	always_comb begin
		result.eq = (stored_key == ref_key);
		result.gt = (stored_key > ref_key);
	end

endmodule

>>> rtl/kpcq_ctrl.sv
// Sequencer of the queue: steps through the store one entry at a time to
// count, compact, insert and take. Depends on kpcq_pkg.
module kpcq_ctrl #(
	parameter int unsigned CAPACITY = kpcq_pkg::CAPACITY_DEFAULT,
	parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                operation,
	input  logic signed [kpcq_pkg::KEY_W-1:0]   key,
	input  logic signed [kpcq_pkg::VALUE_W-1:0] value,
	input  logic                                allow_duplicate,
	output logic                                busy,
	output logic                                done,
	output logic signed [kpcq_pkg::VALUE_W-1:0] taken_value,
	output logic                                was_empty,
	output logic [1:0]                          add_status,
	// Store ports.
	output logic                                mem_we,
	output logic [AW-1:0]                       mem_waddr,
	output logic [kpcq_pkg::ENTRY_W-1:0]        mem_wdata,
	output logic                                mem_re,
	output logic [AW-1:0]                       mem_raddr,
	input  logic [kpcq_pkg::ENTRY_W-1:0]        mem_rdata,
	// Comparator ports.
	output logic signed [kpcq_pkg::KEY_W-1:0]   ref_key,
	input  kpcq_pkg::kpcq_cmp_t                 cmp
);

	localparam int unsigned KW = kpcq_pkg::KEY_W;
	localparam int unsigned VW = kpcq_pkg::VALUE_W;

	kpcq_pkg::kpcq_state_t  state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          idx_q, idx_d;
	logic [CW-1:0]          wr_q, wr_d;
	logic [1:0]             match_q, match_d;
	logic                   done_q, done_d;
	logic [VW-1:0]          taken_q, taken_d;
	logic                   empty_q, empty_d;
	kpcq_pkg::kpcq_status_t status_q, status_d;
	logic [KW-1:0]          key_q;
	logic [VW-1:0]          val_q;
	logic [CW-1:0]          idx_dec;

	assign idx_dec = idx_q - CW'(1);

	// Captured command operands.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q <= key;
			val_q <= value;
		end
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= kpcq_pkg::S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			wr_q     <= '0;
			match_q  <= '0;
			done_q   <= 1'b0;
			taken_q  <= kpcq_pkg::EMPTY_VALUE;
			empty_q  <= 1'b0;
			status_q <= kpcq_pkg::STAT_NOT_ADD;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			wr_q     <= wr_d;
			match_q  <= match_d;
			done_q   <= done_d;
			taken_q  <= taken_d;
			empty_q  <= empty_d;
			status_q <= status_d;
		end
	end

	// Next state, store accesses and results.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		wr_d      = wr_q;
		match_d   = match_q;
		done_d    = 1'b0;
		taken_d   = taken_q;
		empty_d   = empty_q;
		status_d  = status_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = {key_q, val_q};
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];

		case (state_q)
			kpcq_pkg::S_IDLE: begin
				if (start) begin
					if (operation == kpcq_pkg::OP_TAKE) begin
						if (count_q == '0) begin
							done_d   = 1'b1;
							taken_d  = kpcq_pkg::EMPTY_VALUE;
							empty_d  = 1'b1;
							status_d = kpcq_pkg::STAT_NOT_ADD;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = kpcq_pkg::S_TAKE_HEAD;
						end
					end else if (allow_duplicate) begin
						state_d = kpcq_pkg::S_INS_START;
					end else begin
						idx_d   = '0;
						match_d = '0;
						state_d = kpcq_pkg::S_CNT_RD;
					end
				end
			end

			// Count entries holding the key, saturating at two.
			kpcq_pkg::S_CNT_RD: begin
				if (idx_q < count_q) begin
					mem_re  = 1'b1;
					state_d = kpcq_pkg::S_CNT_CHK;
				end else if (match_q == 2'd1) begin
					done_d   = 1'b1;
					taken_d  = kpcq_pkg::EMPTY_VALUE;
					empty_d  = 1'b0;
					status_d = kpcq_pkg::STAT_IGNORED;
					state_d  = kpcq_pkg::S_IDLE;
				end else if (match_q == 2'd2) begin
					idx_d   = '0;
					wr_d    = '0;
					state_d = kpcq_pkg::S_CMP_RD;
				end else begin
					state_d = kpcq_pkg::S_INS_START;
				end
			end

			kpcq_pkg::S_CNT_CHK: begin
				if (cmp.eq && match_q != 2'd2) begin
					match_d = match_q + 2'd1;
				end
				idx_d   = idx_q + CW'(1);
				state_d = kpcq_pkg::S_CNT_RD;
			end

			// Compact the store, dropping every entry with the key.
			kpcq_pkg::S_CMP_RD: begin
				if (idx_q < count_q) begin
					mem_re  = 1'b1;
					state_d = kpcq_pkg::S_CMP_CHK;
				end else begin
					count_d = wr_q;
					state_d = kpcq_pkg::S_INS_START;
				end
			end

			kpcq_pkg::S_CMP_CHK: begin
				if (!cmp.eq) begin
					mem_we    = 1'b1;
					mem_waddr = wr_q[AW-1:0];
					mem_wdata = mem_rdata;
					wr_d      = wr_q + CW'(1);
				end
				idx_d   = idx_q + CW'(1);
				state_d = kpcq_pkg::S_CMP_RD;
			end

			// Insertion: refuse when full, else shift larger keys up.
			kpcq_pkg::S_INS_START: begin
				if (count_q == CW'(CAPACITY)) begin
					done_d   = 1'b1;
					taken_d  = kpcq_pkg::EMPTY_VALUE;
					empty_d  = 1'b0;
					status_d = kpcq_pkg::STAT_DROPPED;
					state_d  = kpcq_pkg::S_IDLE;
				end else begin
					idx_d   = count_q;
					state_d = kpcq_pkg::S_INS_RD;
				end
			end

			kpcq_pkg::S_INS_RD: begin
				if (idx_q == '0) begin
					mem_we   = 1'b1;
					count_d  = count_q + CW'(1);
					done_d   = 1'b1;
					taken_d  = kpcq_pkg::EMPTY_VALUE;
					empty_d  = 1'b0;
					status_d = kpcq_pkg::STAT_INSERTED;
					state_d  = kpcq_pkg::S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = idx_dec[AW-1:0];
					state_d   = kpcq_pkg::S_INS_CHK;
				end
			end

			kpcq_pkg::S_INS_CHK: begin
				mem_we = 1'b1;
				if (cmp.gt) begin
					mem_wdata = mem_rdata;
					idx_d     = idx_dec;
					state_d   = kpcq_pkg::S_INS_RD;
				end else begin
					count_d  = count_q + CW'(1);
					done_d   = 1'b1;
					taken_d  = kpcq_pkg::EMPTY_VALUE;
					empty_d  = 1'b0;
					status_d = kpcq_pkg::STAT_INSERTED;
					state_d  = kpcq_pkg::S_IDLE;
				end
			end

			// Take: keep the head value, then move the rest down by one.
			kpcq_pkg::S_TAKE_HEAD: begin
				taken_d = mem_rdata[VW-1:0];
				idx_d   = CW'(1);
				state_d = kpcq_pkg::S_TAKE_RD;
			end

			kpcq_pkg::S_TAKE_RD: begin
				if (idx_q < count_q) begin
					mem_re  = 1'b1;
					state_d = kpcq_pkg::S_TAKE_WR;
				end else begin
					count_d  = count_q - CW'(1);
					done_d   = 1'b1;
					empty_d  = 1'b0;
					status_d = kpcq_pkg::STAT_NOT_ADD;
					state_d  = kpcq_pkg::S_IDLE;
				end
			end

			kpcq_pkg::S_TAKE_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_dec[AW-1:0];
				mem_wdata = mem_rdata;
				idx_d     = idx_q + CW'(1);
				state_d   = kpcq_pkg::S_TAKE_RD;
			end

			default: begin
				state_d = kpcq_pkg::S_IDLE;
			end
		endcase
	end

	assign busy        = (state_q != kpcq_pkg::S_IDLE);
	assign done        = done_q;
	assign taken_value = taken_q;
	assign was_empty   = empty_q;
	assign add_status  = status_q;
	assign ref_key     = key_q;

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The match counter saturates at two.
	a_match_sat: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= 2'd2)
		else $error("match counter out of range");

	// An empty take reports no add outcome and leaves the store empty.
	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && empty_q) |-> (status_q == kpcq_pkg::STAT_NOT_ADD && count_q == '0))
		else $error("empty take result inconsistent");

	// The insertion shift only writes inside the store.
	a_ins_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kpcq_pkg::S_INS_CHK) |-> (idx_q < CW'(CAPACITY)))
		else $error("insertion index beyond capacity");

endmodule
